/* rtl/civil_date_to_epoch_seconds_defines.svh */
// ----------------------------------------------------------------------------
// Civil date to epoch seconds: assertion macros
// Shared property forms for the checker; each use stands on a line of its own.
// ----------------------------------------------------------------------------
`ifndef CIVIL_DATE_TO_EPOCH_SECONDS_DEFINES_SVH
`define CIVIL_DATE_TO_EPOCH_SECONDS_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted
`define CDES_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error("cdes check failed");

// Next-cycle implication, ignored while reset is asserted
`define CDES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error("cdes check failed");

`endif

/* rtl/cdes_pkg.sv */
// ----------------------------------------------------------------------------
// cdes_pkg
// Item types, calendar constants and the month offset table for the civil
// date to epoch seconds converter.
// ----------------------------------------------------------------------------
`default_nettype none

package cdes_pkg;

    // input item: one UTC civil date and time
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_in;

    // result item
    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic        rejected;
    } t_out;

    localparam logic [13:0] MIN_YEAR        = 14'd2000;
    localparam logic [3:0]  LAST_MONTH      = 4'd12;
    localparam logic [3:0]  FEBRUARY        = 4'd2;
    localparam logic [3:0]  MARCH           = 4'd3;
    localparam logic [3:0]  MARCH_TO_JAN    = 4'd9;
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
    localparam logic [5:0]  SECS_PER_MINUTE = 6'd60;
    localparam logic [17:0] DAYS_PER_ERA    = 18'd146097;
    localparam logic [8:0]  YEARS_PER_ERA   = 9'd400;
    localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
    localparam logic [8:0]  YEARS_PER_CENT  = 9'd100;
    localparam logic [19:0] EPOCH_SHIFT     = 20'd719468;

    // x / 25 as (x * RECIP_25) >> RECIP_SHIFT, exact for x below 1024
    localparam logic [12:0] RECIP_25        = 13'd5243;
    localparam int          RECIP_SHIFT     = 17;

    // first day of each month in a March-based year, (153 * mp + 2) / 5
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

/* rtl/civil_date_to_epoch_seconds.sv */
// ----------------------------------------------------------------------------
// civil_date_to_epoch_seconds
// Five-stage pipeline turning a UTC civil date and time into Unix seconds.
// ----------------------------------------------------------------------------
// One item enters on each cycle with start high and busy low; busy is high
// only while reset is asserted. Every item gives exactly one result, in item
// order, shown on o_result for a single cycle with o_done high. The receiver
// cannot hold results off, so the caller must sample o_result whenever
// o_done is high. The five pipeline registers (input decode, era quotient,
// day of era, day count, seconds) set the latency; throughput is one item
// per clock. An item with a year below 2000, a month outside 1 to 12 or a
// day of zero gives zero with the rejected flag set. The seconds wrap
// modulo 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module civil_date_to_epoch_seconds
    import cdes_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_in  i_item,
    output t_out      o_result,
    output logic      o_done
);

    // stage 1: shift to March-based year, day of year, time of day, checks
    logic        n_acc;
    logic        n_lo_month;
    logic [13:0] n_yy;
    logic [3:0]  n_mp;
    logic [8:0]  n_doy;
    logic [16:0] n_tod;
    logic        n_rej;

    logic        r1_vld;
    logic [13:0] r1_yy;
    logic [8:0]  r1_doy;
    logic [16:0] r1_tod;
    logic        r1_rej;

    assign busy  = ~i_rst_n;
    assign n_acc = start & ~busy;

    always_comb begin
        n_lo_month = (i_item.month <= FEBRUARY);
        n_yy       = i_item.year - {13'd0, n_lo_month};
        n_mp       = n_lo_month ? (i_item.month + MARCH_TO_JAN) : (i_item.month - MARCH);
        n_doy      = month_offset(n_mp) + {4'd0, i_item.day} - 9'd1;
        n_tod      = 17'(i_item.hour) * 17'(SECS_PER_HOUR)
                   + 17'(i_item.minute) * 17'(SECS_PER_MINUTE)
                   + 17'(i_item.second);
        n_rej      = (i_item.year < MIN_YEAR) || (i_item.month == 4'd0)
                   || (i_item.month > LAST_MONTH) || (i_item.day == 5'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= n_acc;
        end
        r1_yy  <= n_yy;
        r1_doy <= n_doy;
        r1_tod <= n_tod;
        r1_rej <= n_rej;
    end

    // stage 2: era = yy / 400 = (yy >> 4) / 25 by reciprocal
    logic [22:0] n_era_prod;
    logic [5:0]  n_era;

    logic        r2_vld;
    logic [13:0] r2_yy;
    logic [5:0]  r2_era;
    logic [8:0]  r2_doy;
    logic [16:0] r2_tod;
    logic        r2_rej;

    always_comb begin
        n_era_prod = 23'(r1_yy[13:4]) * 23'(RECIP_25);
        n_era      = n_era_prod[22:RECIP_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_yy  <= r1_yy;
        r2_era <= n_era;
        r2_doy <= r1_doy;
        r2_tod <= r1_tod;
        r2_rej <= r1_rej;
    end

    // stage 3: year of era and day of era
    logic [13:0] n_yoe_full;
    logic [8:0]  n_yoe;
    logic [1:0]  n_cent;
    logic [17:0] n_doe;

    logic        r3_vld;
    logic [5:0]  r3_era;
    logic [17:0] r3_doe;
    logic [16:0] r3_tod;
    logic        r3_rej;

    always_comb begin
        n_yoe_full = r2_yy - 14'(r2_era) * 14'(YEARS_PER_ERA);
        n_yoe      = n_yoe_full[8:0];
        // yoe / 100 for yoe below 400
        if (n_yoe >= 9'(3 * YEARS_PER_CENT)) begin
            n_cent = 2'd3;
        end else if (n_yoe >= 9'(2 * YEARS_PER_CENT)) begin
            n_cent = 2'd2;
        end else if (n_yoe >= YEARS_PER_CENT) begin
            n_cent = 2'd1;
        end else begin
            n_cent = 2'd0;
        end
        n_doe = 18'(n_yoe) * 18'(DAYS_PER_YEAR) + 18'(n_yoe[8:2])
              - 18'(n_cent) + 18'(r2_doy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_era <= r2_era;
        r3_doe <= n_doe;
        r3_tod <= r2_tod;
        r3_rej <= r2_rej;
    end

    // stage 4: days since 1970-01-01
    logic [23:0] n_days;

    logic        r4_vld;
    logic [23:0] r4_days;
    logic [16:0] r4_tod;
    logic        r4_rej;

    assign n_days = 24'(r3_era) * 24'(DAYS_PER_ERA) + 24'(r3_doe) - 24'(EPOCH_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_days <= n_days;
        r4_tod  <= r3_tod;
        r4_rej  <= r3_rej;
    end

    // stage 5: seconds, wrapping modulo 2^32; zero for a rejected item
    logic [31:0] n_secs;

    logic        r5_vld;
    t_out        r5_res;

    assign n_secs = 32'(r4_days) * 32'(SECS_PER_DAY) + 32'(r4_tod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_res.epoch_seconds <= r4_rej ? 32'd0 : n_secs;
        r5_res.rejected      <= r4_rej;
    end

    assign o_result = r5_res;
    assign o_done   = r5_vld;

endmodule

`default_nettype wire

/* rtl/cdes_checker.sv */
// ----------------------------------------------------------------------------
// cdes_checker
// Port-level checks on the civil date converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "civil_date_to_epoch_seconds_defines.svh"

module cdes_checker
    import cdes_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire t_in  i_item,
    input wire t_out o_result,
    input wire logic o_done
);

    // reset has been released for the whole pipeline depth
    logic [4:0] r_rst_hist;
    logic       settled;
    logic       item_bad;

    always_ff @(posedge i_clk) begin
        r_rst_hist <= {r_rst_hist[3:0], i_rst_n};
    end

    assign settled  = i_rst_n && (&r_rst_hist);
    assign item_bad = (i_item.year < MIN_YEAR) || (i_item.month == 4'd0)
                   || (i_item.month > LAST_MONTH) || (i_item.day == 5'd0);

    // never refuses an item once out of reset
    `CDES_ASSERT_IMPLY(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)

    // one result per item, matched to the accepted item
    `CDES_ASSERT_IMPLY(a_latency, i_clk, i_rst_n, settled, o_done == $past(start && !busy, 5))

    // rejected flag follows the validation of the item it belongs to
    `CDES_ASSERT_IMPLY(a_reject_match, i_clk, i_rst_n, settled && o_done, o_result.rejected == $past(item_bad, 5))

    // a rejected item carries zero seconds
    `CDES_ASSERT_IMPLY(a_reject_zero, i_clk, i_rst_n, o_done && o_result.rejected, o_result.epoch_seconds == 32'd0)

    // no result straight out of reset
    `CDES_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_done)

endmodule

bind civil_date_to_epoch_seconds cdes_checker u_cdes_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_result (o_result),
    .o_done   (o_done)
);

`default_nettype wire

/* bench/cdes_epoch_checker.sv */
// ----------------------------------------------------------------------------
// cdes_epoch_checker
// Watches the item and result channels of the civil date converter, predicts
// each result from the accepted item and compares it in arrival order.
// ----------------------------------------------------------------------------
module cdes_epoch_checker
    import cdes_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_in  i_item,
    input  logic i_done,
    input  t_out i_result,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    // expected conversions, oldest first
    t_out epoch_expected_q[$];

    // days-from-civil with a March-based year, all in 32-bit wrapping arithmetic
    function automatic t_out civil_to_epoch(input t_in it);
        logic [31:0] yy;
        logic [31:0] era;
        logic [31:0] yoe;
        logic [31:0] mp;
        logic [31:0] doy;
        logic [31:0] doe;
        logic [31:0] days;
        t_out        res;
        res = '0;
        if (it.year < MIN_YEAR || it.month == 4'd0 || it.month > LAST_MONTH
                || it.day == 5'd0) begin
            res.rejected = 1'b1;
            return res;
        end
        // January and February belong to the previous March-based year
        yy  = (it.month <= FEBRUARY) ? 32'(it.year) - 32'd1 : 32'(it.year);
        era = yy / YEARS_PER_ERA;
        yoe = yy - era * YEARS_PER_ERA;
        mp  = (it.month > FEBRUARY) ? 32'(it.month) - MARCH
                                    : 32'(it.month) + MARCH_TO_JAN;
        doy = (32'd153 * mp + 32'd2) / 32'd5 + 32'(it.day) - 32'd1;
        doe = yoe * DAYS_PER_YEAR + yoe / 32'd4 - yoe / YEARS_PER_CENT + doy;
        days = era * DAYS_PER_ERA + doe - EPOCH_SHIFT;
        res.epoch_seconds = days * SECS_PER_DAY
                          + 32'(it.hour) * SECS_PER_HOUR
                          + 32'(it.minute) * SECS_PER_MINUTE
                          + 32'(it.second);
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_rejects    = 0;
    end

    // predict on acceptance, compare on every strobe
    always @(posedge i_clk) begin
        t_out exp_res;
        int   errs;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                epoch_expected_q.push_back(civil_to_epoch(i_item));
            if (i_done) begin
                if (epoch_expected_q.size() == 0) begin
                    $error("result strobe with no item outstanding: epoch_seconds %0d",
                           i_result.epoch_seconds);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = epoch_expected_q.pop_front();
                    errs    = 0;
                    o_checked <= o_checked + 1;
                    if (exp_res.rejected)
                        o_rejects <= o_rejects + 1;
                    if (i_result.epoch_seconds !== exp_res.epoch_seconds) begin
                        $error("epoch_seconds: expected %0d, got %0d",
                               exp_res.epoch_seconds, i_result.epoch_seconds);
                        errs++;
                    end
                    if (i_result.rejected !== exp_res.rejected) begin
                        $error("rejected: expected %0b, got %0b",
                               exp_res.rejected, i_result.rejected);
                        errs++;
                    end
                    if (errs != 0)
                        o_fail_count <= o_fail_count + errs;
                end
            end
            o_pending <= epoch_expected_q.size();
        end
    end

endmodule

/* bench/tb_civil_date_to_epoch_seconds.sv */
// ----------------------------------------------------------------------------
// tb_civil_date_to_epoch_seconds
// Drives directed and random civil dates into the converter with random gaps;
// a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_civil_date_to_epoch_seconds;
    import cdes_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1400;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    t_out o_result;
    logic o_done;

    int fail_count;
    int pending;
    int checked;
    int rejects;
    int items_sent;
    int directed_sent;
    int idle_cycles;

    civil_date_to_epoch_seconds uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_result (o_result),
        .o_done   (o_done)
    );

    cdes_epoch_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_rejects    (rejects)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: too long without any item or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in make_date(input int y, input int mo, input int d,
                                      input int h, input int mi, input int s);
        t_in it;
        it.year   = 14'(y);
        it.month  = 4'(mo);
        it.day    = 5'(d);
        it.hour   = 5'(h);
        it.minute = 6'(mi);
        it.second = 6'(s);
        return it;
    endfunction

    // mostly well-formed dates, with some rejects and unchecked time fields
    function automatic t_in random_date();
        int   r;
        t_in  it;
        r = $urandom_range(99, 0);
        if (r < 65)      it.year = 14'($urandom_range(2150, 2000));
        else if (r < 80) it.year = 14'($urandom_range(16383, 2000));
        else if (r < 90) it.year = 14'($urandom_range(16383, 0));
        else             it.year = 14'($urandom_range(2010, 1990));
        it.month  = ($urandom_range(99, 0) < 90) ? 4'($urandom_range(12, 1))
                                                 : 4'($urandom_range(15, 0));
        it.day    = ($urandom_range(99, 0) < 97) ? 5'($urandom_range(31, 1)) : 5'd0;
        it.hour   = ($urandom_range(99, 0) < 90) ? 5'($urandom_range(23, 0))
                                                 : 5'($urandom_range(31, 0));
        it.minute = ($urandom_range(99, 0) < 90) ? 6'($urandom_range(59, 0))
                                                 : 6'($urandom_range(63, 0));
        r = $urandom_range(99, 0);
        if (r < 90)      it.second = 6'($urandom_range(59, 0));
        else if (r < 95) it.second = 6'd60;
        else             it.second = 6'($urandom_range(63, 0));
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_date(input t_in it, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        // busy seen at a falling edge holds through the next rising edge
        while (busy)
            @(negedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 4);
    endfunction

    initial begin
        t_in directed_q[$];
        int  burst;
        start      = 1'b0;
        i_item     = '0;
        i_rst_n    = 1'b0;
        items_sent = 0;
        idle_cycles = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: boundaries, rejects, overflow of day and time fields, wrap
        directed_q.push_back(make_date(2000, 1, 1, 0, 0, 0));
        directed_q.push_back(make_date(2000, 2, 29, 23, 59, 59));
        directed_q.push_back(make_date(2000, 3, 1, 0, 0, 0));
        directed_q.push_back(make_date(2000, 12, 31, 23, 59, 60));
        directed_q.push_back(make_date(1999, 12, 31, 31, 63, 63));
        directed_q.push_back(make_date(0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_date(2024, 0, 15, 12, 0, 0));
        directed_q.push_back(make_date(2024, 13, 15, 12, 0, 0));
        directed_q.push_back(make_date(2024, 15, 15, 12, 0, 0));
        directed_q.push_back(make_date(2024, 6, 0, 12, 0, 0));
        directed_q.push_back(make_date(16383, 15, 31, 31, 63, 63));
        directed_q.push_back(make_date(2023, 2, 31, 8, 30, 0));
        directed_q.push_back(make_date(2024, 4, 31, 0, 0, 0));
        directed_q.push_back(make_date(2024, 7, 4, 31, 63, 63));
        directed_q.push_back(make_date(2038, 1, 19, 3, 14, 7));
        directed_q.push_back(make_date(2038, 1, 19, 3, 14, 8));
        directed_q.push_back(make_date(2106, 2, 7, 6, 28, 15));
        directed_q.push_back(make_date(2106, 2, 7, 6, 28, 16));
        directed_q.push_back(make_date(2100, 2, 28, 23, 59, 59));
        directed_q.push_back(make_date(2100, 3, 1, 0, 0, 0));
        directed_q.push_back(make_date(2400, 2, 29, 12, 0, 0));
        directed_q.push_back(make_date(9999, 12, 31, 23, 59, 59));
        directed_q.push_back(make_date(16383, 1, 1, 0, 0, 0));
        directed_q.push_back(make_date(16383, 12, 31, 23, 59, 59));
        foreach (directed_q[i])
            send_date(directed_q[i], 0);
        directed_sent = items_sent;

        // random: back-to-back bursts broken by gaps of varied length
        burst = 0;
        repeat (RANDOM_ITEMS) begin
            if (burst > 0) begin
                burst--;
                send_date(random_date(), 0);
            end else begin
                if ($urandom_range(9, 0) == 0)
                    burst = $urandom_range(40, 10);
                send_date(random_date(), random_gap());
            end
        end
        start <= 1'b0;

        // drain outstanding results, then allow for any stray strobes
        while (pending != 0 || checked < items_sent)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Converted %0d dates (%0d directed, rest random) with random gaps.",
                 items_sent, directed_sent);
        $display("Checked %0d results, %0d of them rejected dates.", checked, rejects);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* civil_date_to_epoch_seconds.f */
+incdir+rtl
rtl/cdes_pkg.sv
rtl/civil_date_to_epoch_seconds.sv
rtl/cdes_checker.sv
bench/cdes_epoch_checker.sv
bench/tb_civil_date_to_epoch_seconds.sv
